FILE: sv/frp_pkg.sv
// Shared types and codes for the framed packet receiver.
package frp_pkg;

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_LEN     = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_CSUM    = 2'd3;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_GOOD = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    localparam logic [7:0] HEADER_RESET = 8'hAA;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] length_seen;
        logic [7:0] payload_count;
        logic [7:0] running_sum;
    } frp_state_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_length;
    } frp_result_t;

endpackage

FILE: sv/framed_packet_receiver_unit.sv
// Top level of the framed packet receiver: parser state, header register, result register.
// Streaming frame receiver: takes one byte per transaction and gives exactly one result
// per byte (nothing, payload byte with its index, frame good or checksum bad). A byte
// is taken every cycle unless the output stalls; each result is registered. A new byte is
// accepted whenever the result register is empty or being taken in the same cycle.
// The header byte (reset 0xAA) may only be rewritten while the block is idle.
module framed_packet_receiver_unit
    import frp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    output logic [7:0] frame_length
);

    frp_state_t  state_reg;
    frp_state_t  state_next;
    frp_result_t result_reg;
    frp_result_t result_next;
    logic [7:0]  header_reg;
    logic        out_valid_reg;
    logic        in_take;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_take  = in_valid && in_ready;

    frp_step u_step
    (
        .cur          (state_reg),
        .header_value (header_reg),
        .rx_byte      (rx_byte),
        .nxt          (state_next),
        .res          (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{phase: PH_HUNT, length_seen: 8'd0,
                               payload_count: 8'd0, running_sum: 8'd0};
            header_reg    <= HEADER_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                header_reg <= cfg_data;
            end
            if (in_take)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = result_reg.result_kind;
    assign payload_byte  = result_reg.payload_byte;
    assign payload_index = result_reg.payload_index;
    assign frame_length  = result_reg.frame_length;

`ifndef SYNTH
    // index always lies inside the announced length
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_BYTE |-> payload_index < frame_length)
        else $error("payload index beyond frame length");

    a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_PAYLOAD |-> state_reg.payload_count < state_reg.length_seen)
        else $error("payload count reached length while still in payload");

    a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_HUNT |-> state_reg.payload_count == 8'd0)
        else $error("payload count not cleared while hunting");

    // a checksum byte always sends the parser back to hunting
    a_csum_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && state_reg.phase == PH_CSUM |=> state_reg.phase == PH_HUNT)
        else $error("parser did not return to hunting after checksum");
`endif

endmodule

FILE: sv/frp_step.sv
// Per-byte frame parser step: next parser state and the result for one byte.
module frp_step
    import frp_pkg::*;
(
    input  frp_state_t  cur,
    input  logic [7:0]  header_value,
    input  logic [7:0]  rx_byte,
    output frp_state_t  nxt,
    output frp_result_t res
);

    logic [7:0] sum_plus;
    logic [7:0] count_plus;

    assign sum_plus   = cur.running_sum + rx_byte;
    assign count_plus = cur.payload_count + 8'd1;

    always_comb
    begin
        nxt = cur;
        res = '0;
        unique case (cur.phase)
            PH_HUNT:
            begin
                if (rx_byte == header_value)
                begin
                    nxt.running_sum   = rx_byte;
                    nxt.payload_count = '0;
                    nxt.phase         = PH_LEN;
                end
            end
            PH_LEN:
            begin
                nxt.length_seen   = rx_byte;
                nxt.running_sum   = sum_plus;
                nxt.payload_count = '0;
                // zero length skips straight to the checksum
                nxt.phase         = (rx_byte == 8'd0) ? PH_CSUM : PH_PAYLOAD;
                res.frame_length  = rx_byte;
            end
            PH_PAYLOAD:
            begin
                res.result_kind   = KIND_BYTE;
                res.payload_byte  = rx_byte;
                res.payload_index = cur.payload_count;
                res.frame_length  = cur.length_seen;
                nxt.running_sum   = sum_plus;
                nxt.payload_count = count_plus;
                if (count_plus == cur.length_seen)
                begin
                    nxt.phase = PH_CSUM;
                end
            end
            PH_CSUM:
            begin
                res.result_kind   = (rx_byte == cur.running_sum) ? KIND_GOOD : KIND_BAD;
                res.frame_length  = cur.length_seen;
                nxt.phase         = PH_HUNT;
                nxt.payload_count = '0;
            end
        endcase
    end

endmodule

FILE: test/testbench.sv
// Self-checking testbench for framed_packet_receiver_unit: directed rows, then random frames.
module testbench
    import frp_pkg::*;
();

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic [7:0] cfg_data = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_length;

    typedef struct packed {
        logic [7:0]  rx;
        logic        typed;
        frp_result_t res;
    } stim_row_t;

    // Directed rows; header is 0xAA after reset. Untyped rows go to the parser model.
    stim_row_t dir_rows [24] = '{
        {8'h00, 1'b1, KIND_NONE, 8'h00, 8'h00, 8'h00},  // noise while hunting
        {8'hFF, 1'b1, KIND_NONE, 8'h00, 8'h00, 8'h00},
        {8'hAA, 1'b1, KIND_NONE, 8'h00, 8'h00, 8'h00},  // header
        {8'h00, 1'b1, KIND_NONE, 8'h00, 8'h00, 8'h00},  // zero length
        {8'hAA, 1'b1, KIND_GOOD, 8'h00, 8'h00, 8'h00},
        {8'hAA, 1'b1, KIND_NONE, 8'h00, 8'h00, 8'h00},
        {8'h00, 1'b1, KIND_NONE, 8'h00, 8'h00, 8'h00},
        {8'h55, 1'b1, KIND_BAD,  8'h00, 8'h00, 8'h00},
        {8'hAA, 1'b1, KIND_NONE, 8'h00, 8'h00, 8'h00},
        {8'h02, 1'b1, KIND_NONE, 8'h00, 8'h00, 8'h02},
        {8'hAA, 1'b1, KIND_BYTE, 8'hAA, 8'h00, 8'h02},  // header value as payload
        {8'hFF, 1'b1, KIND_BYTE, 8'hFF, 8'h01, 8'h02},
        {8'h55, 1'b0, 26'd0},
        {8'h01, 1'b1, KIND_NONE, 8'h00, 8'h00, 8'h00},
        {8'hAA, 1'b1, KIND_NONE, 8'h00, 8'h00, 8'h00},
        {8'h01, 1'b1, KIND_NONE, 8'h00, 8'h00, 8'h01},
        {8'h00, 1'b1, KIND_BYTE, 8'h00, 8'h00, 8'h01},
        {8'h00, 1'b1, KIND_BAD,  8'h00, 8'h00, 8'h01},
        {8'hAA, 1'b0, 26'd0},
        {8'h03, 1'b0, 26'd0},
        {8'h10, 1'b0, 26'd0},
        {8'h20, 1'b0, 26'd0},
        {8'h30, 1'b0, 26'd0},
        {8'hFF, 1'b0, 26'd0}
    };

    // parser model state
    logic [7:0] header_reg = HEADER_RESET;
    logic [1:0] model_phase = PH_HUNT;
    logic [7:0] model_len = 8'h00;
    logic [7:0] model_count = 8'h00;
    logic [7:0] model_sum = 8'h00;

    frp_result_t pending_results [$];
    frp_result_t predicted;
    frp_result_t want;
    logic        drv_typed = 1'b0;
    frp_result_t drv_res = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int frame_items = 0;
    int mismatches = 0;
    int good_frames = 0;
    int bad_frames = 0;
    int payload_seen = 0;
    int ignored_seen = 0;

    framed_packet_receiver_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_kind(result_kind),
        .payload_byte(payload_byte),
        .payload_index(payload_index),
        .frame_length(frame_length)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic frp_result_t parse_byte(input logic [7:0] b);
        frp_result_t r;
        r = '0;
        r.result_kind = KIND_NONE;
        case (model_phase)
            PH_HUNT:
            begin
                if (b == header_reg)
                begin
                    model_sum = b;
                    model_count = 8'h00;
                    model_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                model_len = b;
                model_sum = model_sum + b;
                model_count = 8'h00;
                model_phase = (b == 8'h00) ? PH_CSUM : PH_PAYLOAD;
                r.frame_length = b;
            end
            PH_PAYLOAD:
            begin
                r.result_kind = KIND_BYTE;
                r.payload_byte = b;
                r.payload_index = model_count;
                r.frame_length = model_len;
                model_sum = model_sum + b;
                model_count = model_count + 8'h01;
                if (model_count == model_len)
                    model_phase = PH_CSUM;
            end
            default:
            begin
                r.result_kind = (b == model_sum) ? KIND_GOOD : KIND_BAD;
                r.frame_length = model_len;
                model_phase = PH_HUNT;
                model_count = 8'h00;
            end
        endcase
        return r;
    endfunction

    task automatic report(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // push on input transaction first, so a result in the same edge still finds it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predicted = parse_byte(rx_byte);
                pending_results.push_back(drv_typed ? drv_res : predicted);
            end
            if (out_valid && out_ready)
            begin
                case (result_kind)
                    KIND_GOOD: good_frames++;
                    KIND_BAD:  bad_frames++;
                    KIND_BYTE: payload_seen++;
                    default:   ignored_seen++;
                endcase
                if (pending_results.size() == 0)
                    report("result with nothing pending");
                else
                begin
                    want = pending_results.pop_front();
                    if (result_kind !== want.result_kind)
                        report($sformatf("result_kind %0d, want %0d",
                                         result_kind, want.result_kind));
                    if (payload_byte !== want.payload_byte)
                        report($sformatf("payload_byte %0h, want %0h",
                                         payload_byte, want.payload_byte));
                    if (payload_index !== want.payload_index)
                        report($sformatf("payload_index %0d, want %0d",
                                         payload_index, want.payload_index));
                    if (frame_length !== want.frame_length)
                        report($sformatf("frame_length %0d, want %0d",
                                         frame_length, want.frame_length));
                end
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic set_idling;
        if (frame_items < 270)
        begin
            send_idle_pct = 28;
            recv_idle_pct = 74;
        end
        else if (frame_items < 540)
        begin
            send_idle_pct = 74;
            recv_idle_pct = 28;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic typed, input frp_result_t res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        drv_typed <= typed;
        drv_res <= res;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // always moves on by at least one falling edge, so the caller may drive again
    task automatic hold_until_drained;
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_header(input logic [7:0] v);
        hold_until_drained();
        repeat (3) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        header_reg = v;
    endtask

    task automatic send_frame(input int len, input bit sum_ok);
        logic [7:0] sum;
        logic [7:0] b;
        sum = header_reg + len[7:0];
        send_byte(header_reg, 1'b0, '0);
        send_byte(len[7:0], 1'b0, '0);
        for (int i = 0; i < len; i++)
        begin
            b = ($urandom_range(9) == 0) ? header_reg : 8'($urandom);
            sum = sum + b;
            send_byte(b, 1'b0, '0);
        end
        if (!sum_ok)
            sum = sum ^ (8'h01 << $urandom_range(7));
        send_byte(sum, 1'b0, '0);
        frame_items += len + 3;
    endtask

    // mostly well-formed frames with random content, with noise and truncated frames
    task automatic random_frames(input int count, input bit long_first);
        int stop_at;
        int len;
        int cut;
        stop_at = frame_items + count;
        while (frame_items < stop_at)
        begin
            set_idling();
            if ($urandom_range(99) < 4)
                hold_until_drained();
            repeat ($urandom_range(0, 3))
                send_byte(8'($urandom), 1'b0, '0);
            if (long_first)
            begin
                long_first = 1'b0;
                send_frame(255, 1'b1);
            end
            else if ($urandom_range(99) < 85)
            begin
                case ($urandom_range(99))
                    0:       len = 255;
                    1, 2, 3: len = $urandom_range(9, 40);
                    default: len = $urandom_range(0, 8);
                endcase
                send_frame(len, $urandom_range(99) < 75);
            end
            else
            begin
                // frame cut short: what follows is taken as its payload
                len = $urandom_range(1, 6);
                cut = $urandom_range(0, len - 1);
                send_byte(header_reg, 1'b0, '0);
                send_byte(len[7:0], 1'b0, '0);
                repeat (cut)
                    send_byte(8'($urandom), 1'b0, '0);
                frame_items += cut + 2;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling();
        foreach (dir_rows[i])
            send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].res);
        frame_items += 24;
        random_frames(140, 1'b0);

        write_header(8'h00);
        random_frames(160, 1'b1);
        write_header(8'hFF);
        random_frames(160, 1'b0);
        write_header(8'($urandom));
        random_frames(160, 1'b0);
        write_header(8'hAA);
        random_frames(160, 1'b0);

        hold_until_drained();
        repeat (10) @(negedge clk);

        $display("covered %0d good and %0d bad frames, %0d payload bytes, %0d idle results",
                 good_frames, bad_frames, payload_seen, ignored_seen);
        $display("header set to 0xAA, 0x00, 0xFF and a random value; stalls both ways, then none");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
